@@ rtl/ifhe_pkg.sv @@
// Types and constants for the Ethernet/IPv4 flow header extractor.
package ifhe_pkg;

  localparam int unsigned OffsetLimit  = 78;
  localparam int unsigned EthHdrLen    = 14;
  localparam int unsigned QueueDepth   = 2;

  localparam logic [15:0] EthertypeIpv4 = 16'h0800;
  localparam logic [7:0]  ProtoTcp      = 8'd6;
  localparam logic [7:0]  ProtoUdp      = 8'd17;
  localparam logic [3:0]  IpVersion4    = 4'd4;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       end_of_frame;
  } in_item_t;

  typedef struct packed {
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [7:0]  ip_protocol;
    logic [16:0] frame_bytes;
  } out_item_t;

  typedef struct packed {
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [31:0] port_bytes;
    logic        ports_ok;
    logic [7:0]  ip_protocol;
    logic [15:0] total_length;
  } rec_t;

endpackage

@@ rtl/ifhe_front.sv @@
// Front end: byte offset counting, header capture and record classification.
module ifhe_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ifhe_pkg::in_item_t in_data_i,
  input  logic              q_full_i,
  output logic              push_o,
  output ifhe_pkg::rec_t    rec_o
);
  import ifhe_pkg::*;

  localparam logic [6:0] OffLim = 7'(OffsetLimit);
  localparam logic [6:0] HdrLen = 7'(EthHdrLen);

  logic [6:0]  off_q, off_d;
  logic [47:0] dmac_q, dmac_d, smac_q, smac_d;
  logic [15:0] etype_q, etype_d, tlen_q, tlen_d;
  logic [7:0]  vihl_q, vihl_d, proto_q, proto_d;
  logic [31:0] sip_q, sip_d, dip_q, dip_d, pbytes_q, pbytes_d;
  logic [6:0]  ps_d, len;
  logic        in_fire, in_range, emit;
  logic [7:0]  b;

  assign in_ready_o = !q_full_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign b          = in_data_i.frame_byte;
  assign in_range   = off_q < OffLim;
  assign ps_d       = HdrLen + {1'b0, vihl_d[3:0], 2'b00};
  assign len        = in_range ? off_q + 7'd1 : OffLim;

  always_comb begin
    dmac_d   = dmac_q;
    smac_d   = smac_q;
    etype_d  = etype_q;
    vihl_d   = vihl_q;
    tlen_d   = tlen_q;
    proto_d  = proto_q;
    sip_d    = sip_q;
    dip_d    = dip_q;
    pbytes_d = pbytes_q;
    if (in_range) begin
      if (off_q inside {[7'd0:7'd5]}) begin
        dmac_d = {dmac_q[39:0], b};
      end else if (off_q inside {[7'd6:7'd11]}) begin
        smac_d = {smac_q[39:0], b};
      end else if (off_q inside {[7'd12:7'd13]}) begin
        etype_d = {etype_q[7:0], b};
      end else if (off_q == 7'd14) begin
        vihl_d = b;
      end else if (off_q inside {[7'd16:7'd17]}) begin
        tlen_d = {tlen_q[7:0], b};
      end else if (off_q == 7'd23) begin
        proto_d = b;
      end else if (off_q inside {[7'd26:7'd29]}) begin
        sip_d = {sip_q[23:0], b};
      end else if (off_q inside {[7'd30:7'd33]}) begin
        dip_d = {dip_q[23:0], b};
      end
      if (off_q >= ps_d && off_q < ps_d + 7'd4) begin
        pbytes_d = {pbytes_q[23:0], b};
      end
    end
  end

  always_comb begin
    if (!in_fire) begin
      off_d = off_q;
    end else if (in_data_i.end_of_frame) begin
      off_d = '0;
    end else if (in_range) begin
      off_d = off_q + 7'd1;
    end else begin
      off_d = off_q;
    end
  end

  assign emit = (len >= HdrLen) && (etype_d == EthertypeIpv4) && (len >= 7'd34) &&
                (vihl_d[7:4] == IpVersion4) && (len >= ps_d);

  assign push_o = in_fire && in_data_i.end_of_frame && emit;

  always_comb begin
    rec_o.dest_mac     = dmac_d;
    rec_o.source_mac   = smac_d;
    rec_o.source_ip    = sip_d;
    rec_o.dest_ip      = dip_d;
    rec_o.port_bytes   = pbytes_d;
    rec_o.ports_ok     = (len >= ps_d + 7'd4) && (proto_d == ProtoTcp || proto_d == ProtoUdp);
    rec_o.ip_protocol  = proto_d;
    rec_o.total_length = tlen_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0;
    end else begin
      off_q <= off_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      dmac_q   <= dmac_d;
      smac_q   <= smac_d;
      etype_q  <= etype_d;
      vihl_q   <= vihl_d;
      tlen_q   <= tlen_d;
      proto_q  <= proto_d;
      sip_q    <= sip_d;
      dip_q    <= dip_d;
      pbytes_q <= pbytes_d;
    end
  end

  a_off_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    off_q <= OffLim) else $error("byte offset past limit");
  a_eof_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.end_of_frame |=> off_q == 7'd0)
    else $error("offset not cleared at frame end");
  a_push_eof: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> len >= 7'd34) else $error("record from short frame");

endmodule

@@ rtl/ifhe_queue.sv @@
// Short record queue between the front and back ends.
module ifhe_queue #(
  parameter int unsigned Depth = ifhe_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ifhe_pkg::rec_t push_data_i,
  output logic           full_o,
  output logic           empty_o,
  input  logic           pop_i,
  output ifhe_pkg::rec_t pop_data_o
);
  import ifhe_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  rec_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o     = cnt_q == FullCnt;
  assign empty_o    = cnt_q == '0;
  assign pop_data_o = mem_q[rd_q];

  assign wr_d  = push_i ? ((wr_q == LastPtr) ? '0 : wr_q + 1'b1) : wr_q;
  assign rd_d  = pop_i  ? ((rd_q == LastPtr) ? '0 : rd_q + 1'b1) : rd_q;
  assign cnt_d = cnt_q + CntW'(push_i) - CntW'(pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  a_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_unf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt) else $error("queue count out of range");

endmodule

@@ rtl/ifhe_back.sv @@
// Back end: port selection, byte count and output register.
module ifhe_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  ifhe_pkg::rec_t      q_data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ifhe_pkg::out_item_t out_data_o
);
  import ifhe_pkg::*;

  logic      vld_q, vld_d;
  out_item_t out_q, out_d;

  assign pop_o = !q_empty_i && (!vld_q || out_ready_i);
  assign vld_d = pop_o || (vld_q && !out_ready_i);

  always_comb begin
    out_d.dest_mac    = q_data_i.dest_mac;
    out_d.source_mac  = q_data_i.source_mac;
    out_d.source_ip   = q_data_i.source_ip;
    out_d.dest_ip     = q_data_i.dest_ip;
    out_d.source_port = q_data_i.ports_ok ? q_data_i.port_bytes[31:16] : 16'd0;
    out_d.dest_port   = q_data_i.ports_ok ? q_data_i.port_bytes[15:0] : 16'd0;
    out_d.ip_protocol = q_data_i.ip_protocol;
    out_d.frame_bytes = {1'b0, q_data_i.total_length} + 17'(EthHdrLen);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = out_q;

  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> vld_q) else $error("popped record not registered");
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> out_q.frame_bytes >= 17'(EthHdrLen)) else $error("byte count too small");
  a_ports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && !q_data_i.ports_ok |=> out_q.source_port == 16'd0 && out_q.dest_port == 16'd0)
    else $error("ports not cleared");

endmodule

@@ rtl/ipv4_flow_header_extractor_unit.sv @@
// Top level of the Ethernet/IPv4 flow header extractor.
// Throughput: one frame byte per cycle unless the record queue is full; no gaps between frames.
// A record is written into the queue when its end-of-frame byte is taken, then moves on into
// the output register once that register is empty or its current item is being taken.
// Input stalls only while the record queue is full.
// Reset clears the byte offset, queue pointers and output valid; captured fields are not reset.
module ipv4_flow_header_extractor_unit #(
  parameter int unsigned QueueDepth = ifhe_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ifhe_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ifhe_pkg::out_item_t out_data_o
);
  import ifhe_pkg::*;

  logic q_full, q_empty, push, pop;
  rec_t push_rec, pop_rec;

  ifhe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .rec_o      (push_rec)
  );

  ifhe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_rec),
    .full_o      (q_full),
    .empty_o     (q_empty),
    .pop_i       (pop),
    .pop_data_o  (pop_rec)
  );

  ifhe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (pop_rec),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
